@@ rtl/core/i2cms_pkg.sv @@
// Package for the I2C master byte sequencer: item and result layouts,
// command and segment codes, and the segment decode helpers.
// No dependencies.
`default_nettype none

package i2cms_pkg;

  localparam int ItemW = 13;
  localparam int ResW  = 13;
  localparam int DataW = 16;

  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
  localparam logic [3:0] IDX_POLL_START = 4'd9;
  localparam logic [3:0] IDX_POLL_STOP  = 4'd10;

  // Delay register indexes on the configuration port.
  localparam logic REG_SHORT = 1'b0;
  localparam logic REG_LONG  = 1'b1;

  typedef enum logic [2:0] {
    KIND_IDLE  = 3'd0,
    KIND_START = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_WRITE = 3'd3,
    KIND_READ  = 3'd4,
    KIND_POLL  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    SEG_START = 2'd0,
    SEG_STOP  = 2'd1,
    SEG_OUT   = 2'd2,
    SEG_IN    = 2'd3
  } seg_t;

  // Input item, opcode in the lowest bits.
  typedef struct packed {
    logic       sda_in;
    logic       ack_to_send;
    logic [7:0] write_byte;
    logic [2:0] opcode;
  } item_t;

  // Result item, scl_level in the lowest bit.
  typedef struct packed {
    logic       ack_seen;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_level;
    logic       scl_level;
  } res_t;

  // Status of the sequencer state, for checks in the top level.
  typedef struct packed {
    logic busy;
    logic dly_zero;
  } stat_t;

  function automatic seg_t seg_of(input kind_t kind, input logic [3:0] bidx);
    seg_t s;
    unique case (kind)
      KIND_START: s = SEG_START;
      KIND_STOP:  s = SEG_STOP;
      KIND_WRITE: s = (bidx < BITS_PER_BYTE) ? SEG_OUT : SEG_IN;
      KIND_READ:  s = (bidx < BITS_PER_BYTE) ? SEG_IN : SEG_OUT;
      default: begin
        if (bidx == IDX_POLL_START) s = SEG_START;
        else if (bidx == IDX_POLL_STOP) s = SEG_STOP;
        else s = (bidx < BITS_PER_BYTE) ? SEG_OUT : SEG_IN;
      end
    endcase
    return s;
  endfunction

  function automatic logic [2:0] seg_len(input seg_t s);
    return (s == SEG_START || s == SEG_IN) ? 3'd4 : 3'd3;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/i2cms_core.sv @@
// Sequencer state and its one-item step: phases, delay counter, bit index,
// shift and receive bytes, pin drives. Depends on i2cms_pkg.
`default_nettype none

module i2cms_core
  import i2cms_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         step_en,
  input  item_t       item,
  input  wire  [7:0]  short_delay,
  input  wire  [7:0]  long_delay,
  output res_t        res,
  output stat_t       stat
);

  kind_t      kind_r, kind_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [3:0] bidx_r, bidx_nxt;
  logic [7:0] dly_r, dly_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       ack_r, ack_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       done;

  logic [7:0] dly_s, dly_l;

  assign dly_s = (short_delay == 8'd0) ? 8'd1 : short_delay;
  assign dly_l = (long_delay == 8'd0) ? 8'd1 : long_delay;

  always_comb begin
    logic   do_enter;
    logic   fin;
    logic   obit;
    seg_t   seg;
    kind_nxt  = kind_r;
    phase_nxt = phase_r;
    bidx_nxt  = bidx_r;
    dly_nxt   = dly_r;
    shift_nxt = shift_r;
    rx_nxt    = rx_r;
    ack_nxt   = ack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    done      = 1'b0;
    do_enter  = 1'b0;
    fin       = 1'b0;

    if (kind_r == KIND_IDLE) begin
      if (item.opcode >= KIND_START && item.opcode <= KIND_POLL) begin
        kind_nxt  = kind_t'(item.opcode);
        phase_nxt = 3'd0;
        bidx_nxt  = (item.opcode == KIND_POLL) ? IDX_POLL_START : 4'd0;
        shift_nxt = (item.opcode == KIND_READ) ? {7'd0, item.ack_to_send} : item.write_byte;
        if (item.opcode == KIND_READ) rx_nxt = 8'd0;
        do_enter = 1'b1;
      end
    end else if (dly_r > 8'd1) begin
      dly_nxt = dly_r - 8'd1;
    end else begin
      phase_nxt = phase_r + 3'd1;
      if (phase_nxt >= seg_len(seg_of(kind_r, bidx_r))) begin
        phase_nxt = 3'd0;
        // Move on to the next segment of the command, or finish it.
        if (kind_r == KIND_START || kind_r == KIND_STOP) begin
          fin = 1'b1;
        end else if (kind_r == KIND_POLL) begin
          if (bidx_r == IDX_POLL_START) bidx_nxt = 4'd0;
          else if (bidx_r == IDX_POLL_STOP) fin = 1'b1;
          else if (bidx_r == BITS_PER_BYTE) bidx_nxt = ack_r ? IDX_POLL_START : IDX_POLL_STOP;
          else bidx_nxt = bidx_r + 4'd1;
        end else if (bidx_r >= BITS_PER_BYTE) begin
          fin = 1'b1;
        end else begin
          bidx_nxt = bidx_r + 4'd1;
        end
        if (fin) begin
          kind_nxt = KIND_IDLE;
          bidx_nxt = 4'd0;
          dly_nxt  = 8'd0;
          done     = 1'b1;
        end
      end
      if (kind_nxt != KIND_IDLE) do_enter = 1'b1;
    end

    seg  = seg_of(kind_nxt, bidx_nxt);
    obit = (bidx_nxt < BITS_PER_BYTE) ? shift_nxt[3'd7 - bidx_nxt[2:0]] : shift_nxt[0];

    if (do_enter) begin
      unique case (seg)
        SEG_START: begin
          unique case (phase_nxt)
            3'd0: begin sda_nxt = 1'b1; dly_nxt = dly_s; end
            3'd1: begin scl_nxt = 1'b1; dly_nxt = dly_l; end
            3'd2: begin sda_nxt = 1'b0; dly_nxt = dly_l; end
            default: begin scl_nxt = 1'b0; dly_nxt = dly_l; end
          endcase
        end
        SEG_STOP: begin
          unique case (phase_nxt)
            3'd0: begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
            3'd1: scl_nxt = 1'b1;
            default: sda_nxt = 1'b1;
          endcase
          dly_nxt = dly_l;
        end
        SEG_OUT: begin
          unique case (phase_nxt)
            3'd0: begin scl_nxt = 1'b0; sda_nxt = obit; dly_nxt = dly_s; end
            3'd1: begin scl_nxt = 1'b1; dly_nxt = dly_l; end
            default: begin scl_nxt = 1'b0; dly_nxt = dly_s; end
          endcase
        end
        default: begin
          unique case (phase_nxt)
            3'd0: begin scl_nxt = 1'b0; dly_nxt = dly_s; end
            3'd1: begin sda_nxt = 1'b1; dly_nxt = dly_s; end
            3'd2: begin scl_nxt = 1'b1; dly_nxt = dly_l; end
            default: begin scl_nxt = 1'b0; dly_nxt = dly_s; end
          endcase
        end
      endcase
    end

    // SDA is sampled on the last tick of the SCL-high phase of a bit in.
    if (kind_nxt != KIND_IDLE && seg == SEG_IN && phase_nxt == 3'd2 && dly_nxt == 8'd1) begin
      if (kind_nxt == KIND_READ && bidx_nxt < BITS_PER_BYTE) rx_nxt = {rx_nxt[6:0], item.sda_in};
      else ack_nxt = item.sda_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_IDLE;
      phase_r <= 3'd0;
      bidx_r  <= 4'd0;
      dly_r   <= 8'd0;
      shift_r <= 8'd0;
      rx_r    <= 8'd0;
      ack_r   <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else if (step_en) begin
      kind_r  <= kind_nxt;
      phase_r <= phase_nxt;
      bidx_r  <= bidx_nxt;
      dly_r   <= dly_nxt;
      shift_r <= shift_nxt;
      rx_r    <= rx_nxt;
      ack_r   <= ack_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

  assign res.scl_level = scl_nxt;
  assign res.sda_level = sda_nxt;
  assign res.busy_res  = (kind_nxt != KIND_IDLE);
  assign res.done_res  = done;
  assign res.read_data = rx_nxt;
  assign res.ack_seen  = ack_nxt;

  assign stat.busy     = (kind_r != KIND_IDLE);
  assign stat.dly_zero = (dly_r == 8'd0);

endmodule

`default_nettype wire

@@ rtl/core/i2c_master_byte_sequencer_top.sv @@
// Top level of the I2C master byte sequencer: input register, delay
// configuration registers, sequencer core and result register.
// A result item is registered in the result register when the core steps on
// the input item held in the input register. Throughput: one item per cycle
// while results are taken; the sequencer step is one short pass.
// Reset: synchronous, active low; both delays return to short 3, long 5.
// Pins come out of reset released high, no command in progress.
`default_nettype none

module i2c_master_byte_sequencer_top
  import i2cms_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  // Input item stream.
  input  wire               in_tvalid,
  output logic              in_tready,
  // opcode[2:0], write_byte[10:3], ack_to_send[11], sda_in[12], zero pad.
  input  wire  [DataW-1:0]  in_tdata,
  // Result item stream.
  output logic              out_tvalid,
  input  wire               out_tready,
  // scl_level[0], sda_level[1], busy_res[2], done_res[3], read_data[11:4],
  // ack_seen[12], zero pad.
  output logic [DataW-1:0]  out_tdata,
  // Configuration writes: index 0 short delay, index 1 long delay.
  input  wire               cfg_wr_en,
  input  wire               cfg_addr,
  input  wire  [7:0]        cfg_wdata
);

  // The input register holds one item until the core steps on it. The core
  // steps whenever the result register is empty or is being drained, so
  // items pass at one per cycle while results are taken. A stalled result
  // lets one more item wait in the input register before in_tready drops.
  logic       in_valid_r;
  item_t      in_item_r;
  logic       out_valid_r;
  res_t       out_res_r;
  logic [7:0] short_delay_r;
  logic [7:0] long_delay_r;
  logic       advance;
  res_t       core_res;
  stat_t      core_stat;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= item_t'(in_tdata[ItemW-1:0]);
    end
  end

  // Delay writes take effect at once; they must be made only while no item is
  // in flight, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_delay_r <= 8'd3;
      long_delay_r  <= 8'd5;
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_SHORT) short_delay_r <= cfg_wdata;
      else long_delay_r <= cfg_wdata;
    end
  end

  i2cms_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .item        (in_item_r),
    .short_delay (short_delay_r),
    .long_delay  (long_delay_r),
    .res         (core_res),
    .stat        (core_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(DataW-ResW){1'b0}}, out_res_r};

`ifndef SYNTHESIS
  // A finishing tick never reports the command as still running.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.done_res && out_res_r.busy_res))
    else $error("done and busy both set in a result item");

  // With no command running the delay counter has been cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    !core_stat.busy |-> core_stat.dly_zero)
    else $error("delay counter nonzero while idle");

  // The core steps only while the result register can take its result.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> (!out_valid_r || out_tready) && in_valid_r)
    else $error("core stepped while the result register was stalled");

  // A result reported busy comes from a core that is busy afterwards.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && core_res.busy_res |=> core_stat.busy)
    else $error("busy result without a running command");
`endif

endmodule

`default_nettype wire
